[src/nfc_rfc_pkg.sv]
`timescale 1ns / 1ps

package nfc_rfc_pkg;

    localparam logic [7:0] ZERO_BYTE      = 8'h00;
    localparam logic [7:0] START_BYTE     = 8'hFF;
    localparam logic [7:0] DIRECTION_BYTE = 8'hD5;
    localparam logic [7:0] MIN_LENGTH     = 8'd2;

    // Frame positions with fixed meaning
    localparam logic [8:0] POS_START     = 9'd2;
    localparam logic [8:0] POS_LENGTH    = 9'd3;
    localparam logic [8:0] POS_LCS       = 9'd4;
    localparam logic [8:0] POS_DIRECTION = 9'd5;
    localparam logic [8:0] POS_CODE      = 9'd6;
    localparam logic [8:0] POS_MAX       = 9'd511;
    // Offsets of DCS and postamble past the length byte count
    localparam logic [8:0] DCS_OFFSET    = 9'd5;
    localparam logic [8:0] POST_OFFSET   = 9'd6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PREAMBLE  = 3'd1,
        ST_LENGTH    = 3'd2,
        ST_DIRECTION = 3'd3,
        ST_CODE      = 3'd4,
        ST_CHECKSUM  = 3'd5,
        ST_POSTAMBLE = 3'd6,
        ST_TRUNCATED = 3'd7
    } status_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       buffer_end;
        logic [7:0] expected_code;
        logic [7:0] capacity;
    } item_t;

    typedef struct packed {
        logic       is_verdict;
        logic [7:0] payload_byte;
        status_t    status;
        logic [7:0] payload_length;
    } result_t;

endpackage

[src/nfc_rfc_in_reg.sv]
`timescale 1ns / 1ps

module nfc_rfc_in_reg
    import nfc_rfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item_in,
    input  logic  step,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Room when empty or when the held item moves on this cycle
    assign item_ready = !valid_reg || step;
    assign take       = item_valid && item_ready;
    assign valid_next = take ? 1'b1 : (step ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[src/nfc_rfc_checker.sv]
`timescale 1ns / 1ps

module nfc_rfc_checker
    import nfc_rfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    logic [8:0] pos_reg;
    logic [8:0] pos_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] copied_reg;
    logic [7:0] copied_next;
    logic [7:0] cap_reg;
    logic [7:0] cap_next;
    logic [7:0] code_reg;
    logic [7:0] code_next;
    logic       given_reg;
    logic       given_next;

    logic [7:0] b;
    logic [7:0] code_eff;
    logic [7:0] cap_eff;
    logic [8:0] dcs_pos;
    logic [8:0] post_pos;
    logic [7:0] lcs_sum;
    logic [7:0] sum_add;
    logic       verdict;
    logic       emit;
    status_t    st;

    assign b        = item.frame_byte;
    assign code_eff = (pos_reg == '0) ? item.expected_code : code_reg;
    assign cap_eff  = (pos_reg == '0) ? item.capacity : cap_reg;
    assign dcs_pos  = {1'b0, len_reg} + DCS_OFFSET;
    assign post_pos = {1'b0, len_reg} + POST_OFFSET;
    assign lcs_sum  = len_reg + b;
    assign sum_add  = sum_reg + b;

    // Per-byte check, decided by position in the frame
    always_comb
    begin
        verdict  = 1'b0;
        emit     = 1'b0;
        st       = ST_OK;
        len_next = len_reg;
        sum_next = sum_reg;
        if (pos_reg < POS_START)
        begin
            if (b != ZERO_BYTE)
            begin
                verdict = 1'b1;
                st      = ST_PREAMBLE;
            end
        end
        else if (pos_reg == POS_START)
        begin
            if (b != START_BYTE)
            begin
                verdict = 1'b1;
                st      = ST_PREAMBLE;
            end
        end
        else if (pos_reg == POS_LENGTH)
        begin
            len_next = b;
        end
        else if (pos_reg == POS_LCS)
        begin
            if (lcs_sum != ZERO_BYTE || len_reg < MIN_LENGTH)
            begin
                verdict = 1'b1;
                st      = ST_LENGTH;
            end
        end
        else if (pos_reg == post_pos)
        begin
            verdict = 1'b1;
            st      = (b == ZERO_BYTE) ? ST_OK : ST_POSTAMBLE;
        end
        else
        begin
            sum_next = sum_add;
            if (pos_reg == POS_DIRECTION)
            begin
                if (b != DIRECTION_BYTE)
                begin
                    verdict = 1'b1;
                    st      = ST_DIRECTION;
                end
            end
            else if (pos_reg == POS_CODE && b != code_eff)
            begin
                verdict = 1'b1;
                st      = ST_CODE;
            end
            else if (pos_reg == dcs_pos)
            begin
                if (sum_add != ZERO_BYTE)
                begin
                    verdict = 1'b1;
                    st      = ST_CHECKSUM;
                end
            end
            else if (copied_reg < cap_eff)
            begin
                emit = 1'b1;
            end
        end
        // Early end on a byte that passed its checks
        if (!verdict && item.buffer_end)
        begin
            verdict = 1'b1;
            st      = ST_TRUNCATED;
            emit    = 1'b0;
        end
    end

    always_comb
    begin
        pos_next    = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : pos_reg;
        code_next   = code_eff;
        cap_next    = cap_eff;
        copied_next = emit ? copied_reg + 8'd1 : copied_reg;
        given_next  = verdict;
        if ((given_reg || verdict) && item.buffer_end)
        begin
            pos_next    = '0;
            code_next   = '0;
            cap_next    = '0;
            copied_next = '0;
            given_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            copied_reg <= '0;
            cap_reg    <= '0;
            code_reg   <= '0;
            given_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (given_reg)
            begin
                // Skip to buffer end after the verdict
                if (item.buffer_end)
                begin
                    pos_reg    <= '0;
                    len_reg    <= '0;
                    sum_reg    <= '0;
                    copied_reg <= '0;
                    cap_reg    <= '0;
                    code_reg   <= '0;
                    given_reg  <= 1'b0;
                end
            end
            else
            begin
                pos_reg    <= pos_next;
                len_reg    <= (verdict && item.buffer_end) ? 8'd0 : len_next;
                sum_reg    <= (verdict && item.buffer_end) ? 8'd0 : sum_next;
                copied_reg <= copied_next;
                cap_reg    <= cap_next;
                code_reg   <= code_next;
                given_reg  <= given_next;
            end
        end
    end

    assign res_valid          = !given_reg && (verdict || emit);
    assign res.is_verdict     = verdict;
    assign res.payload_byte   = verdict ? 8'd0 : b;
    assign res.status         = st;
    assign res.payload_length = (verdict && st == ST_OK) ? copied_reg : 8'd0;

    // No result between a verdict and the buffer end
    a_quiet_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        given_reg |-> !res_valid)
        else $error("result produced after verdict");

    // A buffer end always starts the next buffer afresh
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.buffer_end) |=> (pos_reg == '0 && !given_reg && copied_reg == '0))
        else $error("buffer end did not clear frame state");

    // Delivered payload never exceeds the held capacity
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> (copied_reg <= cap_reg))
        else $error("payload count beyond capacity");

endmodule

[src/nfc_rfc_out_reg.sv]
`timescale 1ns / 1ps

module nfc_rfc_out_reg
    import nfc_rfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    result_ready,
    output logic    result_valid,
    output logic    free,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held result is taken now
    assign free       = !valid_reg || result_ready;
    assign valid_next = load ? 1'b1 : (result_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign result_valid = valid_reg;
    assign res_out      = res_reg;

endmodule

[src/nfc_response_frame_checker.sv]
`timescale 1ns / 1ps

// Response frame checker: takes a received buffer one byte per item and
// checks preamble 00 00 FF, LEN/LCS (LEN at least 2), direction byte D5,
// the expected response code, the data checksum DCS and the 00 postamble.
// The code byte and data bytes come out as payload results as they arrive
// (is_verdict = 0), up to the capacity sampled on the first byte; keep them
// only if the verdict is ok. One verdict result (is_verdict = 1) is given
// per buffer: at the postamble, at the first failing byte, or at a buffer
// end that comes too early (truncated). After a verdict, bytes produce no
// result until the byte carrying buffer_end, and the next byte starts a new
// buffer. expected_code and capacity are sampled on the first byte of each
// buffer. Throughput is one byte per clock while results are taken. An
// accepted byte is held in the input register; the single-pass byte check
// then writes frame state and the result register together, and the
// result register holds its result, shown on result_valid, until it is
// taken. While the result register holds a result that is not taken, the
// held byte waits in the input register even if it would make no result,
// and item_ready drops once that register is full.
module nfc_response_frame_checker
    import nfc_rfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] frame_byte,
    input  logic       buffer_end,
    input  logic [7:0] expected_code,
    input  logic [7:0] capacity,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       is_verdict,
    output logic [7:0] payload_byte,
    output logic [2:0] status,
    output logic [7:0] payload_length
);

    item_t   item_in;
    item_t   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t res_out;

    assign item_in.frame_byte    = frame_byte;
    assign item_in.buffer_end    = buffer_end;
    assign item_in.expected_code = expected_code;
    assign item_in.capacity      = capacity;

    // The held byte is checked once the result register can take its result
    assign step = held_valid && out_free;

    nfc_rfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_in    (item_in),
        .step       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    nfc_rfc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    nfc_rfc_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && res_valid),
        .res_in       (res),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .free         (out_free),
        .res_out      (res_out)
    );

    assign is_verdict     = res_out.is_verdict;
    assign payload_byte   = res_out.payload_byte;
    assign status         = res_out.status;
    assign payload_length = res_out.payload_length;

endmodule
